// ----- rtl/efla_pkg.sv -----
package efla_pkg;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Request opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic        op;
    logic [31:0] address;
    logic [31:0] length;
    logic [31:0] align_hint;
  } req_t;

  typedef struct packed {
    logic [31:0] granted_address;
    logic [1:0]  status;
  } rsp_t;

  // One free extent as stored in the table
  typedef struct packed {
    logic [31:0] base;
    logic [31:0] len;
  } entry_t;

endpackage

// ----- rtl/extent_free_list_allocator_top.sv -----
// First-fit free-extent allocator with coalescing. The free extents sit in an
// address-sorted table in one RAM; a small sequencer walks it one entry at a
// time. How long a request takes grows with the entries scanned, the alignment
// steps tried, and the entries moved when a split or an insert opens a slot or a
// merge closes one; it is set by the one-entry-per-step table walk and the
// alignment search. req_ready is high only while the block is idle; one
// response beat follows each request.
module extent_free_list_allocator_top #(
  parameter int MAX_EXTENTS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  efla_pkg::req_t   req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output efla_pkg::rsp_t   rsp
);

  localparam int IW = $clog2(MAX_EXTENTS);
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_EXTENTS);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_EVAL, S_ALIGN, S_DECIDE, S_MRG_RD, S_MRG,
    S_UP_RD, S_UP_WR, S_DN_RD, S_DN_WR, S_OUT
  } state_t;

  state_t           state;
  logic [CW-1:0]    cnt;
  logic [CW-1:0]    i;
  logic [CW-1:0]    j;
  logic [CW-1:0]    ins_pos;
  efla_pkg::entry_t ins_ent;
  logic             op;
  logic [31:0]      addr;
  logic [31:0]      size;
  logic [31:0]      hint;
  logic [31:0]      ob;
  logic [31:0]      ol;
  logic [31:0]      offset;
  logic [31:0]      newlen;
  logic [4:0]       k;
  logic [4:0]       klog;

  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  efla_pkg::entry_t wr_data;
  logic [IW-1:0]    rd_addr;
  efla_pkg::entry_t rd_data;

  logic [31:0]      mask;
  logic [31:0]      align_off;
  logic [31:0]      tot;
  logic [31:0]      end_addr;

  efla_ram #(
    .WIDTH($bits(efla_pkg::entry_t)),
    .DEPTH(MAX_EXTENTS)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // Floor of log2 of the request size, size zero counting as one
  always_comb begin
    klog = 5'd0;
    for (int b = 1; b < 32; b++) begin
      if (size[b]) begin
        klog = 5'(b);
      end
    end
  end

  // Shared alignment and cut arithmetic
  assign mask      = (32'h1 << k) - 32'h1;
  assign align_off = (hint - ob) & mask;
  assign tot       = offset + size;
  assign end_addr  = rd_data.base + rd_data.len;

  // Select the read address for the current step
  always_comb begin
    case (state)
      S_RD:     rd_addr = i[IW-1:0];
      S_MRG_RD: rd_addr = IW'(i + CW'(1));
      S_UP_RD:  rd_addr = IW'(j - CW'(1));
      S_DN_RD:  rd_addr = IW'(j + CW'(1));
      default:  rd_addr = i[IW-1:0];
    endcase
  end

  assign req_ready = (state == S_IDLE);
  assign rsp_valid = (state == S_OUT);

  always_ff @(posedge clk) begin : seq_blk
    logic wr_en_next;
    wr_en_next = 1'b0;
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        // Take a request and start the scan
        S_IDLE: begin
          if (req_valid) begin
            op    <= req.op;
            addr  <= req.address;
            size  <= req.length;
            hint  <= req.align_hint;
            i     <= '0;
            state <= S_RD;
          end
        end

        // Read entry i, or end the scan past the last entry
        S_RD: begin
          if (i == cnt) begin
            if (op == efla_pkg::OP_ALLOC) begin
              rsp   <= '{granted_address: 32'd0, status: efla_pkg::ST_NOFIT};
              state <= S_OUT;
            end else if (cnt >= CNT_MAX) begin
              rsp   <= '{granted_address: 32'd0, status: efla_pkg::ST_FULL};
              state <= S_OUT;
            end else begin
              rsp     <= '{granted_address: 32'd0, status: efla_pkg::ST_OK};
              ins_pos <= i;
              ins_ent <= '{base: addr, len: size};
              j       <= cnt;
              state   <= S_UP_RD;
            end
          end else begin
            state <= S_EVAL;
          end
        end

        // Test entry i against the request
        S_EVAL: begin
          ob <= rd_data.base;
          ol <= rd_data.len;
          if (op == efla_pkg::OP_ALLOC) begin
            if (rd_data.len < size ||
                (addr != 32'd0 && (addr < rd_data.base || addr + size > end_addr))) begin
              i     <= i + CW'(1);
              state <= S_RD;
            end else if (addr != 32'd0) begin
              offset <= addr - rd_data.base;
              state  <= S_DECIDE;
            end else begin
              k     <= klog;
              state <= S_ALIGN;
            end
          end else begin
            if (end_addr < addr) begin
              i     <= i + CW'(1);
              state <= S_RD;
            end else if (end_addr == addr) begin
              // Grow left neighbor, then check the right one
              newlen     <= rd_data.len + size;
              wr_en_next = 1'b1;
              wr_addr    <= i[IW-1:0];
              wr_data    <= '{base: rd_data.base, len: rd_data.len + size};
              rsp        <= '{granted_address: 32'd0, status: efla_pkg::ST_OK};
              state      <= (i + CW'(1) < cnt) ? S_MRG_RD : S_OUT;
            end else if (addr + size == rd_data.base) begin
              wr_en_next = 1'b1;
              wr_addr    <= i[IW-1:0];
              wr_data    <= '{base: addr, len: rd_data.len + size};
              rsp        <= '{granted_address: 32'd0, status: efla_pkg::ST_OK};
              state      <= S_OUT;
            end else if (cnt >= CNT_MAX) begin
              rsp   <= '{granted_address: 32'd0, status: efla_pkg::ST_FULL};
              state <= S_OUT;
            end else begin
              rsp     <= '{granted_address: 32'd0, status: efla_pkg::ST_OK};
              ins_pos <= i;
              ins_ent <= '{base: addr, len: size};
              j       <= cnt;
              state   <= S_UP_RD;
            end
          end
        end

        // Step the alignment modulus down until the piece fits
        S_ALIGN: begin
          if (align_off + size <= ol || k == 5'd0) begin
            offset <= align_off;
            state  <= S_DECIDE;
          end else begin
            k <= k - 5'd1;
          end
        end

        // Cut the extent: split, trim either end, or drop it; a split with a full table reports full
        S_DECIDE: begin
          if (offset != 32'd0 && tot < ol) begin
            if (cnt >= CNT_MAX) begin
              rsp   <= '{granted_address: 32'd0, status: efla_pkg::ST_FULL};
              state <= S_OUT;
            end else begin
              rsp        <= '{granted_address: ob + offset, status: efla_pkg::ST_OK};
              wr_en_next = 1'b1;
              wr_addr    <= i[IW-1:0];
              wr_data    <= '{base: ob, len: offset};
              ins_pos    <= i + CW'(1);
              ins_ent    <= '{base: ob + tot, len: ol - tot};
              j          <= cnt;
              state      <= S_UP_RD;
            end
          end else if (offset != 32'd0) begin
            rsp        <= '{granted_address: ob + offset, status: efla_pkg::ST_OK};
            wr_en_next = 1'b1;
            wr_addr    <= i[IW-1:0];
            wr_data    <= '{base: ob, len: offset};
            state      <= S_OUT;
          end else if (tot < ol) begin
            rsp        <= '{granted_address: ob + offset, status: efla_pkg::ST_OK};
            wr_en_next = 1'b1;
            wr_addr    <= i[IW-1:0];
            wr_data    <= '{base: ob + tot, len: ol - tot};
            state      <= S_OUT;
          end else begin
            rsp   <= '{granted_address: ob + offset, status: efla_pkg::ST_OK};
            j     <= i;
            state <= S_DN_RD;
          end
        end

        // Read the right neighbor for a three-way merge
        S_MRG_RD: begin
          state <= S_MRG;
        end

        S_MRG: begin
          if (ob + newlen == rd_data.base) begin
            wr_en_next = 1'b1;
            wr_addr    <= i[IW-1:0];
            wr_data    <= '{base: ob, len: newlen + rd_data.len};
            j          <= i + CW'(1);
            state      <= S_DN_RD;
          end else begin
            state <= S_OUT;
          end
        end

        // Open a slot: move entries up one, then drop in the new one
        S_UP_RD: begin
          if (j == ins_pos) begin
            wr_en_next = 1'b1;
            wr_addr    <= j[IW-1:0];
            wr_data    <= ins_ent;
            cnt        <= cnt + CW'(1);
            state      <= S_OUT;
          end else begin
            state <= S_UP_WR;
          end
        end

        S_UP_WR: begin
          wr_en_next = 1'b1;
          wr_addr    <= j[IW-1:0];
          wr_data    <= rd_data;
          j          <= j - CW'(1);
          state      <= S_UP_RD;
        end

        // Close a slot: move entries down one
        S_DN_RD: begin
          if (j + CW'(1) >= cnt) begin
            cnt   <= cnt - CW'(1);
            state <= S_OUT;
          end else begin
            state <= S_DN_WR;
          end
        end

        S_DN_WR: begin
          wr_en_next = 1'b1;
          wr_addr    <= j[IW-1:0];
          wr_data    <= rd_data;
          j          <= j + CW'(1);
          state      <= S_DN_RD;
        end

        // Hold the response beat until taken
        S_OUT: begin
          if (rsp_ready) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
    wr_en <= wr_en_next;
  end

endmodule

// ----- rtl/efla_ram.sv -----
module efla_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, register the read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
